// ----- rtl/core/hblt_pkg.sv -----
// ----------------------------------------------------------------------------
// hblt_pkg
// Shared types and sizes for the bucketed hash lookup table.
// ----------------------------------------------------------------------------
`default_nettype none

package hblt_pkg;

  // The bucket count is a power of two, so the bucket is the low key bits.
  localparam int BUCKET_BITS = 4;
  localparam int NUM_BUCKETS = 1 << BUCKET_BITS;
  localparam int WAYS        = 4;
  localparam int KEY_W       = 32;
  localparam int VALUE_W     = 32;

  typedef enum logic {
    CMD_LOOKUP = 1'b0,
    CMD_UPDATE = 1'b1
  } cmd_t;

  typedef logic signed [KEY_W-1:0]   key_t;
  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [BUCKET_BITS-1:0]    bucket_t;
  typedef logic [WAYS-1:0]           way_mask_t;

  typedef struct packed {
    key_t   [WAYS-1:0] keys;
    value_t [WAYS-1:0] values;
  } row_t;

  typedef struct packed {
    logic    en;
    bucket_t addr;
    row_t    row;
  } row_wr_t;

  typedef struct packed {
    value_t read_value;
    logic   found;
    logic   status;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/hblt_ifs.sv -----
// ----------------------------------------------------------------------------
// hblt channel interfaces
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface hblt_in_if import hblt_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   cmd;
  key_t   key;
  value_t new_value;
  value_t miss_value;

  modport source(output valid, cmd, key, new_value, miss_value, input ready);
  modport sink(input valid, cmd, key, new_value, miss_value, output ready);
endinterface

interface hblt_out_if import hblt_pkg::*; ();
  logic   valid;
  logic   ready;
  value_t read_value;
  logic   found;
  logic   status;

  modport source(output valid, read_value, found, status, input ready);
  modport sink(input valid, read_value, found, status, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/hblt_row_ram.sv -----
// ----------------------------------------------------------------------------
// hblt_row_ram
// One row per bucket holding all ways; registered read, write-first bypass.
// ----------------------------------------------------------------------------
`default_nettype none

module hblt_row_ram import hblt_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rd_en,
  input  wire bucket_t rd_addr,
  input  wire row_wr_t wr,
  output row_t         rd_data
);

  row_t mem [NUM_BUCKETS];
  row_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.row;
    end
    if (rd_en) begin
      // A row written in the same cycle is passed straight to the reader.
      if (wr.en && (wr.addr == rd_addr)) begin
        rd_data_r <= wr.row;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- rtl/core/hblt_bucket_logic.sv -----
// ----------------------------------------------------------------------------
// hblt_bucket_logic
// Compares all ways of one bucket and forms the result and the updated row.
// ----------------------------------------------------------------------------
`default_nettype none

module hblt_bucket_logic import hblt_pkg::*; (
  input  wire logic      cmd,
  input  wire key_t      key,
  input  wire value_t    new_value,
  input  wire value_t    miss_value,
  input  wire row_t      row,
  input  wire way_mask_t valid,
  output result_t        result,
  output row_t           row_upd,
  output way_mask_t      valid_upd,
  output logic           wr_en
);

  way_mask_t hit_oh;
  way_mask_t free_oh;
  logic      hit;
  logic      free;
  value_t    hit_value;

  always_comb begin
    hit       = 1'b0;
    free      = 1'b0;
    hit_oh    = '0;
    free_oh   = '0;
    hit_value = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (valid[w]) begin
        if (!hit && (row.keys[w] == key)) begin
          hit       = 1'b1;
          hit_oh[w] = 1'b1;
        end
      end else if (!free) begin
        free       = 1'b1;
        free_oh[w] = 1'b1;
      end
    end
    for (int w = 0; w < WAYS; w++) begin
      hit_value = hit_value | (row.values[w] & {VALUE_W{hit_oh[w]}});
    end
  end

  always_comb begin
    row_upd   = row;
    valid_upd = valid;
    for (int w = 0; w < WAYS; w++) begin
      if (hit_oh[w]) begin
        row_upd.values[w] = new_value;
      end else if (!hit && free_oh[w]) begin
        row_upd.keys[w]   = key;
        row_upd.values[w] = new_value;
        valid_upd[w]      = 1'b1;
      end
    end
  end

  always_comb begin
    wr_en  = 1'b0;
    result = '0;
    if (cmd == CMD_UPDATE) begin
      wr_en         = hit || free;
      result.found  = hit;
      result.status = !hit && !free;
    end else begin
      result.found      = hit;
      result.read_value = hit ? hit_value : miss_value;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/bucketed_hash_lookup_table.sv -----
// ----------------------------------------------------------------------------
// bucketed_hash_lookup_table
// Key/value table with set-associative buckets: lookup or add-or-update.
// ----------------------------------------------------------------------------
// An accepted item passes through the lookup stage and the output register
// before its result can be taken.
// Throughput: one item per cycle unless the output stalls; the bucket row is
// read on acceptance, compared and written back in the lookup stage, with
// a bypass on the row memory read port. Reset clears all valid bits; no
// clearing pass is needed. Key and value storage is undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module bucketed_hash_lookup_table import hblt_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  hblt_in_if.sink    in_ch,
  hblt_out_if.source out_ch
);

  logic      s1_valid_r;
  logic      s1_cmd_r;
  key_t      s1_key_r;
  value_t    s1_new_value_r;
  value_t    s1_miss_value_r;
  logic      out_valid_r;
  result_t   out_result_r;

  logic [NUM_BUCKETS-1:0][WAYS-1:0] valid_r;

  logic      in_acc;
  logic      s1_adv;
  bucket_t   s1_bucket;
  row_t      rd_row;
  row_t      row_upd;
  way_mask_t valid_cur;
  way_mask_t valid_upd;
  logic      upd_en;
  result_t   result;
  row_wr_t   wr;

  assign s1_adv       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || s1_adv;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign s1_bucket    = s1_key_r[BUCKET_BITS-1:0];
  assign valid_cur    = valid_r[s1_bucket];

  assign wr.en   = s1_adv && upd_en;
  assign wr.addr = s1_bucket;
  assign wr.row  = row_upd;

  hblt_row_ram u_row_ram (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (in_ch.key[BUCKET_BITS-1:0]),
    .wr      (wr),
    .rd_data (rd_row)
  );

  hblt_bucket_logic u_bucket_logic (
    .cmd        (s1_cmd_r),
    .key        (s1_key_r),
    .new_value  (s1_new_value_r),
    .miss_value (s1_miss_value_r),
    .row        (rd_row),
    .valid      (valid_cur),
    .result     (result),
    .row_upd    (row_upd),
    .valid_upd  (valid_upd),
    .wr_en      (upd_en)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (wr.en) begin
        valid_r[s1_bucket] <= valid_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r        <= in_ch.cmd;
      s1_key_r        <= in_ch.key;
      s1_new_value_r  <= in_ch.new_value;
      s1_miss_value_r <= in_ch.miss_value;
    end
    if (s1_adv) begin
      out_result_r <= result;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_value = out_result_r.read_value;
  assign out_ch.found      = out_result_r.found;
  assign out_ch.status     = out_result_r.status;

  // A held item keeps its key until it moves on.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_key_r))
    else $error("held item changed in the lookup stage");

  // A dropped insert never writes the row memory.
  a_drop_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && result.status |-> !upd_en)
    else $error("full bucket insert wrote the row memory");

  // Valid bits of a bucket are never cleared by a write.
  a_valid_keep: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |=> ((valid_r[$past(s1_bucket)] & $past(valid_cur)) == $past(valid_cur)))
    else $error("write cleared a valid bit");

  // Input backpressure only when both the lookup stage and output are full.
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> s1_valid_r && out_valid_r && !out_ch.ready)
    else $error("input stalled without a full pipeline");

endmodule

`default_nettype wire

// ----- dv/tb_bucketed_hash_lookup_table.sv -----
// ----------------------------------------------------------------------------
// tb_bucketed_hash_lookup_table
// Self-checking testbench for the bucketed hash lookup table. A behavioral
// copy of the bucket store predicts every result in request order, and each
// result is compared field by field. The stimulus starts with directed
// requests and then moves to random traffic over a small key pool, so that
// buckets fill up. Both channels stall at random, and there is one long
// result hold-off and one pause until all results are back.
// ----------------------------------------------------------------------------
module tb_bucketed_hash_lookup_table;
  import hblt_pkg::*;

  localparam int NUM_ENTRIES    = NUM_BUCKETS * WAYS;
  localparam int POOL_SIZE      = NUM_BUCKETS * 6;
  localparam int HOLDOFF_CYCLES = 40;
  localparam int MAX_PRINTED    = 100;

  logic clk;
  logic rst_n;

  hblt_in_if  in_ch();
  hblt_out_if out_ch();

  bucketed_hash_lookup_table DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  key_t   shadow_keys   [NUM_ENTRIES];
  value_t shadow_values [NUM_ENTRIES];
  bit     shadow_valid  [NUM_ENTRIES];

  result_t awaited_results[$];
  key_t    key_pool[POOL_SIZE];

  int src_idle_pct  = 28;
  int snk_stall_pct = 28;
  bit holdoff_req   = 1'b0;
  int holdoff_left  = 0;

  int error_count      = 0;
  int items_sent       = 0;
  int results_checked  = 0;
  int lookups_seen     = 0;
  int lookup_hits      = 0;
  int updates_in_place = 0;
  int fresh_inserts    = 0;
  int dropped_inserts  = 0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic result_t predict_table_access(cmd_t op, key_t k, value_t nv, value_t dflt);
    logic [63:0] k64;
    int          base;
    int          hit;
    int          free_way;
    result_t     r;
    k64      = {{(64 - KEY_W){k[KEY_W-1]}}, k};
    base     = int'(k64 % NUM_BUCKETS) * WAYS;
    hit      = -1;
    free_way = -1;
    r        = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (shadow_valid[base + w]) begin
        if (hit < 0 && shadow_keys[base + w] == k) hit = w;
      end else if (free_way < 0) begin
        free_way = w;
      end
    end
    if (op == CMD_LOOKUP) begin
      lookups_seen++;
      if (hit >= 0) begin
        r.found      = 1'b1;
        r.read_value = shadow_values[base + hit];
        lookup_hits++;
      end else begin
        r.read_value = dflt;
      end
    end else if (hit >= 0) begin
      r.found                    = 1'b1;
      shadow_values[base + hit]  = nv;
      updates_in_place++;
    end else if (free_way >= 0) begin
      shadow_keys[base + free_way]   = k;
      shadow_values[base + free_way] = nv;
      shadow_valid[base + free_way]  = 1'b1;
      fresh_inserts++;
    end else begin
      r.status = 1'b1;
      dropped_inserts++;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (error_count < MAX_PRINTED) begin
      $display("MISMATCH at %0t: %s got %h, expected %h", $time, what, got, want);
    end
    error_count++;
  endtask

  // Result side: random stalls, plus a long hold-off when one is requested.
  always @(negedge clk) begin
    if (holdoff_req) begin
      holdoff_left = HOLDOFF_CYCLES;
      holdoff_req  = 1'b0;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      results_checked++;
      if (awaited_results.size() == 0) begin
        report_mismatch("result with no pending request, read_value", out_ch.read_value, '0);
      end else begin
        want = awaited_results.pop_front();
        if (out_ch.read_value !== want.read_value) begin
          report_mismatch("read_value", out_ch.read_value, want.read_value);
        end
        if (out_ch.found !== want.found) begin
          report_mismatch("found", 32'(out_ch.found), 32'(want.found));
        end
        if (out_ch.status !== want.status) begin
          report_mismatch("status", 32'(out_ch.status), 32'(want.status));
        end
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(cmd_t op, key_t k, value_t nv, value_t dflt);
    result_t pred;
    if ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= op;
    in_ch.key        <= k;
    in_ch.new_value  <= nv;
    in_ch.miss_value <= dflt;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    pred            = predict_table_access(op, k, nv, dflt);
    awaited_results = {awaited_results, pred};
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_for_all_results();
    in_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
  endtask

  function automatic key_t pick_key();
    int roll;
    roll = $urandom_range(99);
    if (roll < 85) return key_pool[$urandom_range(POOL_SIZE - 1)];
    if (roll < 95) return key_t'($urandom());
    case ($urandom_range(3))
      0:       return '0;
      1:       return {1'b0, {(KEY_W - 1){1'b1}}};
      2:       return {1'b1, {(KEY_W - 1){1'b0}}};
      default: return '1;
    endcase
  endfunction

  task automatic send_random_request();
    cmd_t op;
    op = ($urandom_range(1) == 0) ? CMD_LOOKUP : CMD_UPDATE;
    send_request(op, pick_key(), value_t'($urandom()), value_t'($urandom()));
  endtask

  task automatic test_empty_lookups();
    send_request(CMD_LOOKUP, 32'sh0000_0000, 32'sh1234_5678, 32'sh0000_0000);
    send_request(CMD_LOOKUP, 32'sh7FFF_FFFF, 32'sh0000_0000, 32'sh8000_0000);
    send_request(CMD_LOOKUP, 32'sh8000_0000, 32'shFFFF_FFFF, 32'sh7FFF_FFFF);
    send_request(CMD_LOOKUP, 32'shFFFF_FFFF, 32'sh5555_5555, 32'shFFFF_FFFF);
  endtask

  task automatic test_insert_and_update();
    send_request(CMD_UPDATE, 32'sh0000_0007, 32'shA5A5_A5A5, 32'sh0000_0000);
    send_request(CMD_LOOKUP, 32'sh0000_0007, 32'sh0000_0000, 32'sh1111_1111);
    send_request(CMD_UPDATE, 32'sh0000_0007, 32'sh5A5A_5A5A, 32'shFFFF_FFFF);
    send_request(CMD_LOOKUP, 32'sh0000_0007, 32'shFFFF_FFFF, 32'sh2222_2222);
    send_request(CMD_UPDATE, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0000);
    send_request(CMD_LOOKUP, 32'sh7FFF_FFFF, 32'sh0000_0000, 32'sh0000_0000);
    send_request(CMD_UPDATE, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000);
    send_request(CMD_LOOKUP, 32'sh8000_0000, 32'sh0000_0000, 32'shFFFF_FFFF);
  endtask

  // A negative key and a positive key that share the low bits land in the
  // same bucket but must stay distinct entries.
  task automatic test_negative_keys();
    send_request(CMD_UPDATE, -32'sd13, 32'shDEAD_BEEF, 32'sh0000_0000);
    send_request(CMD_UPDATE, 32'sd3, 32'shCAFE_F00D, 32'sh0000_0000);
    send_request(CMD_LOOKUP, -32'sd13, 32'sh0000_0000, 32'sh0BAD_0BAD);
    send_request(CMD_LOOKUP, 32'sd3, 32'sh0000_0000, 32'sh0BAD_0BAD);
    send_request(CMD_LOOKUP, -32'sd1, 32'sh0000_0000, 32'sh1357_9BDF);
  endtask

  task automatic test_full_bucket();
    send_request(CMD_UPDATE, 32'sd9, 32'sh0000_0009, 32'sh0000_0000);
    send_request(CMD_UPDATE, 32'sd25, 32'sh0000_0019, 32'sh0000_0000);
    send_request(CMD_UPDATE, -32'sd7, 32'shFFFF_FFF9, 32'sh0000_0000);
    send_request(CMD_UPDATE, 32'sd41, 32'sh0000_0029, 32'sh0000_0000);
    send_request(CMD_UPDATE, 32'sd57, 32'sh0000_0039, 32'sh0000_0000);
    send_request(CMD_LOOKUP, 32'sd57, 32'sh0000_0000, 32'h7777_7777);
    send_request(CMD_UPDATE, 32'sd25, 32'sh2525_2525, 32'sh0000_0000);
    send_request(CMD_LOOKUP, 32'sd25, 32'sh0000_0000, 32'h7777_7777);
  endtask

  task automatic test_random_traffic(int count);
    key_t k;
    for (int i = 0; i < POOL_SIZE; i++) begin
      k                     = key_t'($urandom());
      k[BUCKET_BITS-1:0]    = bucket_t'(i % NUM_BUCKETS);
      key_pool[i]           = k;
    end
    for (int i = 0; i < count; i++) begin
      if (i == count / 3) begin
        src_idle_pct  = 0;
        snk_stall_pct = 0;
      end else if (i == 2 * count / 3) begin
        src_idle_pct  = 28;
        snk_stall_pct = 28;
      end
      send_random_request();
    end
  endtask

  task automatic test_result_backpressure();
    src_idle_pct = 0;
    holdoff_req  = 1'b1;
    repeat (40) send_random_request();
    src_idle_pct = 28;
  endtask

  task automatic test_pause_until_drained();
    repeat (20) send_random_request();
    wait_for_all_results();
    repeat (20) send_random_request();
  endtask

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.cmd        = CMD_LOOKUP;
    in_ch.key        = '0;
    in_ch.new_value  = '0;
    in_ch.miss_value = '0;
    out_ch.ready     = 1'b0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      shadow_keys[i]   = '0;
      shadow_values[i] = '0;
      shadow_valid[i]  = 1'b0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_empty_lookups();
    test_insert_and_update();
    test_negative_keys();
    test_full_bucket();
    test_random_traffic(500);
    test_result_backpressure();
    test_pause_until_drained();

    wait_for_all_results();
    repeat (10) @(posedge clk);

    $display("Sent %0d requests and checked %0d results: %0d lookups with %0d hits,",
             items_sent, results_checked, lookups_seen, lookup_hits);
    $display("%0d fresh inserts, %0d updates in place, %0d inserts dropped on full buckets.",
             fresh_inserts, updates_in_place, dropped_inserts);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
